[sv/msb_first_bit_packer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bit packer
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define MFBP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define MFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MFBP_ASSERT(label, clk, rst_n, prop)
`define MFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/mfbp_pkg.sv]
// ----------------------------------------------------------------------------
// Bit packer package
// Widths, constants and the control and status bundles of the packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbp_pkg;

    localparam int unsigned BYTE_BITS     = 8;
    localparam int unsigned MAX_CODE_BITS = 32;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned COUNT_W       = 6;
    localparam int unsigned FREE_W        = 4;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PAD   = 1'b1
    } t_command;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic emit_req;
        logic finish;
        logic slot_free;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/mfbp_if.sv]
// ----------------------------------------------------------------------------
// Bit packer channels
// Valid/ready channels for input items and output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfbp_in_if import mfbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] bit_count;
    logic               fill_bit;

    modport source (output valid, output command, output value, output bit_count,
                    output fill_bit, input ready);
    modport sink   (input valid, input command, input value, input bit_count,
                    input fill_bit, output ready);
endinterface

interface mfbp_out_if import mfbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[sv/mfbp_ctrl.sv]
// ----------------------------------------------------------------------------
// Bit packer controller
// Takes one item at a time and steps the datapath once per output byte, or once for an item that emits none.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbp_ctrl import mfbp_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   go;

    assign go = !i_status.emit_req || i_status.slot_free;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                o_cmd.step = go;
                if (go && i_status.finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[sv/mfbp_datapath.sv]
// ----------------------------------------------------------------------------
// Bit packer datapath
// Holds the open byte, the current item and the output byte register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "msb_first_bit_packer_defines.svh"

module mfbp_datapath import mfbp_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  wire                  i_command,
    input  wire [VALUE_W-1:0]    i_value,
    input  wire [COUNT_W-1:0]    i_bit_count,
    input  wire                  i_fill_bit,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [BYTE_BITS-1:0] o_out_byte,
    output logic                 o_out_last
);

    localparam logic [FREE_W-1:0]  FREE_EMPTY = FREE_W'(BYTE_BITS);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(MAX_CODE_BITS);
    localparam logic [COUNT_W-1:0] COUNT_BYTE = COUNT_W'(BYTE_BITS);

    function automatic logic [BYTE_BITS-1:0] lo_mask(input logic [FREE_W-1:0] f);
        lo_mask = {BYTE_BITS{1'b1}} >> (FREE_EMPTY - f);
    endfunction

    logic [BYTE_BITS-1:0] r_open, n_open;
    logic [FREE_W-1:0]    r_free, n_free;
    logic                 r_cmd;
    logic [VALUE_W-1:0]   r_value;
    logic [COUNT_W-1:0]   r_n, n_n;
    logic                 r_fill;
    logic                 r_ovalid;
    logic [BYTE_BITS-1:0] r_obyte, n_obyte;
    logic                 r_olast;

    logic                 emit_req;
    logic                 finish;
    logic [COUNT_W-1:0]   sh;
    logic [VALUE_W-1:0]   shifted;
    logic [BYTE_BITS-1:0] fmask;
    logic [BYTE_BITS-1:0] base_open;
    logic [FREE_W-1:0]    base_free;
    logic [2:0]           rn;
    logic [BYTE_BITS-1:0] bits;

    always_comb begin
        fmask     = lo_mask(r_free);
        sh        = r_n - {2'b00, r_free};
        shifted   = r_value >> sh;
        emit_req  = 1'b0;
        finish    = 1'b1;
        n_obyte   = r_open | (shifted[BYTE_BITS-1:0] & fmask);
        n_open    = r_open;
        n_free    = r_free;
        n_n       = r_n;
        base_open = r_open;
        base_free = r_free;
        rn        = r_n[2:0];
        bits      = '0;
        if (r_cmd == CMD_PAD) begin
            emit_req = (r_free != FREE_EMPTY);
            n_obyte  = (r_open & ~fmask) | (r_fill ? fmask : '0);
            n_open   = '0;
            n_free   = FREE_EMPTY;
        end else begin
            if (r_n >= {2'b00, r_free}) begin
                emit_req  = 1'b1;
                finish    = (sh < COUNT_BYTE);
                base_open = '0;
                base_free = FREE_EMPTY;
                rn        = sh[2:0];
                n_n       = sh;
            end
            bits = r_value[BYTE_BITS-1:0] & ~({BYTE_BITS{1'b1}} << rn);
            if (finish) begin
                n_open = base_open | (bits << (base_free - {1'b0, rn}));
                n_free = base_free - {1'b0, rn};
            end else begin
                n_open = '0;
                n_free = FREE_EMPTY;
            end
        end
    end

    assign o_status.emit_req  = emit_req;
    assign o_status.finish    = finish;
    assign o_status.slot_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= '0;
            r_free   <= FREE_EMPTY;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_open <= n_open;
                r_free <= n_free;
            end
            if (i_cmd.step && emit_req) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_value <= i_value;
            r_n     <= (i_bit_count > COUNT_MAX) ? COUNT_MAX : i_bit_count;
            r_fill  <= i_fill_bit;
        end else if (i_cmd.step) begin
            r_n <= n_n;
        end
        if (i_cmd.step && emit_req) begin
            r_obyte <= n_obyte;
            r_olast <= finish;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;

    `MFBP_ASSERT(a_free_range, i_clk, i_rst_n, (r_free != '0) && (r_free <= FREE_EMPTY))
    `MFBP_ASSERT(a_unused_zero, i_clk, i_rst_n, (r_open & lo_mask(r_free)) == '0)
    `MFBP_ASSERT_NEXT(a_pad_empties, i_clk, i_rst_n, i_cmd.step && (r_cmd == CMD_PAD), (r_free == FREE_EMPTY) && (r_open == '0))

endmodule

`default_nettype wire

[sv/msb_first_bit_packer.sv]
// An accepted item is loaded into the item registers, and its output bytes reach the byte register
// through later steps; a new item is taken only after the last step of the current one, and
// the byte-wide step unit produces one byte per cycle while the output channel is not stalled.
// A stalled output channel holds the step unit until the byte register is taken.
// Reset (synchronous, active low) empties the open byte and the output register.
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Appends variable-length codes to a byte stream and pads the open byte.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer import mfbp_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mfbp_in_if.sink       i_in,
    mfbp_out_if.source    o_out
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       in_ready;

    mfbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mfbp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_command   (i_in.command),
        .i_value     (i_in.value),
        .i_bit_count (i_in.bit_count),
        .i_fill_bit  (i_in.fill_bit),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
